@@ hdl/sccd_pkg.sv @@
// Package: command codes, target codes and the queue entry type for the command deframer.
package sccd_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CMD_SN_DATA    = 8'h50;
    localparam logic [7:0] CMD_SN_VARIANT = 8'h52;
    localparam logic [7:0] CMD_FM         = 8'h51;
    localparam logic [7:0] CMD_AY         = 8'hA0;
    localparam logic [7:0] CMD_GT         = 8'hB0;
    localparam logic [7:0] CMD_WT_PCM     = 8'hC0;
    localparam logic [7:0] CMD_SCC        = 8'hD2;

    localparam logic [7:0] PCM_REG_LO = 8'h15;
    localparam logic [7:0] PCM_REG_HI = 8'h33;

    localparam logic [7:0] ACK_GOOD = 8'hAA;
    localparam logic [7:0] ACK_BAD  = 8'hFF;

    localparam logic [2:0] TGT_SN_DATA    = 3'd0;
    localparam logic [2:0] TGT_SN_VARIANT = 3'd1;
    localparam logic [2:0] TGT_FM         = 3'd2;
    localparam logic [2:0] TGT_AY         = 3'd3;
    localparam logic [2:0] TGT_GT         = 3'd4;
    localparam logic [2:0] TGT_WT         = 3'd5;
    localparam logic [2:0] TGT_PCM        = 3'd6;
    localparam logic [2:0] TGT_SCC        = 3'd7;

    typedef struct packed {
        logic       pair;
        logic       write_valid;
        logic [2:0] target;
        logic [7:0] reg_addr;
        logic [7:0] data_a;
        logic [7:0] data_b;
        logic       ack_valid;
        logic [7:0] ack_byte;
    } sccd_entry_t;

endpackage

@@ hdl/sccd_front.sv @@
// Front end: frame parser that classifies received bytes and pushes completed frames.
module sccd_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 queue_full,
    input  logic [7:0]           rx_byte,
    output logic                 in_stall,
    output logic                 push,
    output sccd_pkg::sccd_entry_t push_entry
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_OP1  = 4'b0010,
        PH_OP2  = 4'b0100,
        PH_OP3  = 4'b1000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] op1_reg, op1_next;
    logic [7:0] op2_reg, op2_next;
    logic       accept;
    logic       good;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign good     = ((cmd_reg ^ op1_reg ^ op2_reg) == rx_byte);

    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        op1_next   = op1_reg;
        op2_next   = op2_reg;
        push       = 1'b0;
        push_entry = '0;
        if (accept)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (rx_byte inside {sccd_pkg::CMD_SN_DATA, sccd_pkg::CMD_SN_VARIANT,
                                        sccd_pkg::CMD_FM, sccd_pkg::CMD_AY, sccd_pkg::CMD_GT,
                                        sccd_pkg::CMD_WT_PCM, sccd_pkg::CMD_SCC})
                    begin
                        cmd_next   = rx_byte;
                        phase_next = PH_OP1;
                    end
                end
                PH_OP1:
                begin
                    if (cmd_reg inside {sccd_pkg::CMD_SN_DATA, sccd_pkg::CMD_SN_VARIANT})
                    begin
                        phase_next             = PH_IDLE;
                        push                   = 1'b1;
                        push_entry.write_valid = 1'b1;
                        push_entry.target      = (cmd_reg == sccd_pkg::CMD_SN_DATA) ?
                                                 sccd_pkg::TGT_SN_DATA :
                                                 sccd_pkg::TGT_SN_VARIANT;
                        push_entry.data_a      = rx_byte;
                    end
                    else if (cmd_reg inside {sccd_pkg::CMD_FM, sccd_pkg::CMD_AY,
                                             sccd_pkg::CMD_GT, sccd_pkg::CMD_WT_PCM,
                                             sccd_pkg::CMD_SCC})
                    begin
                        op1_next   = rx_byte;
                        phase_next = PH_OP2;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_OP2:
                begin
                    if (cmd_reg == sccd_pkg::CMD_AY)
                    begin
                        phase_next             = PH_IDLE;
                        push                   = 1'b1;
                        push_entry.write_valid = 1'b1;
                        push_entry.target      = sccd_pkg::TGT_AY;
                        push_entry.reg_addr    = op1_reg;
                        push_entry.data_a      = rx_byte;
                    end
                    else if (cmd_reg inside {sccd_pkg::CMD_FM, sccd_pkg::CMD_GT,
                                             sccd_pkg::CMD_WT_PCM, sccd_pkg::CMD_SCC})
                    begin
                        op2_next   = rx_byte;
                        phase_next = PH_OP3;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_OP3:
                begin
                    phase_next = PH_IDLE;
                    if (cmd_reg == sccd_pkg::CMD_SCC)
                    begin
                        push                   = 1'b1;
                        push_entry.pair        = 1'b1;
                        push_entry.write_valid = 1'b1;
                        push_entry.target      = sccd_pkg::TGT_SCC;
                        push_entry.reg_addr    = {op1_reg[6:0], 1'b0};
                        push_entry.data_a      = op2_reg;
                        push_entry.data_b      = rx_byte;
                    end
                    else if (cmd_reg == sccd_pkg::CMD_GT)
                    begin
                        if (good)
                        begin
                            push                   = 1'b1;
                            push_entry.write_valid = 1'b1;
                            push_entry.target      = sccd_pkg::TGT_GT;
                            push_entry.reg_addr    = op1_reg;
                            push_entry.data_a      = op2_reg;
                        end
                    end
                    else if (cmd_reg inside {sccd_pkg::CMD_FM, sccd_pkg::CMD_WT_PCM})
                    begin
                        push                 = 1'b1;
                        push_entry.ack_valid = 1'b1;
                        if (good)
                        begin
                            push_entry.ack_byte    = sccd_pkg::ACK_GOOD;
                            push_entry.write_valid = 1'b1;
                            push_entry.reg_addr    = op1_reg;
                            push_entry.data_a      = op2_reg;
                            if (cmd_reg == sccd_pkg::CMD_FM)
                                push_entry.target = sccd_pkg::TGT_FM;
                            else if (op1_reg inside {[sccd_pkg::PCM_REG_LO:sccd_pkg::PCM_REG_HI]})
                                push_entry.target = sccd_pkg::TGT_PCM;
                            else
                                push_entry.target = sccd_pkg::TGT_WT;
                        end
                        else
                        begin
                            push_entry.ack_byte = sccd_pkg::ACK_BAD;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cmd_reg   <= '0;
            op1_reg   <= '0;
            op2_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            op1_reg   <= op1_next;
            op2_reg   <= op2_next;
        end
    end

endmodule

@@ hdl/sccd_queue.sv @@
// Queue: small FIFO of completed frames between parser and output stage.
module sccd_queue
#(
    parameter int DEPTH = sccd_pkg::QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  sccd_pkg::sccd_entry_t push_entry,
    input  logic                  pop,
    output logic                  full,
    output logic                  empty,
    output sccd_pkg::sccd_entry_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    sccd_pkg::sccd_entry_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ hdl/sccd_back.sv @@
// Back end: output register that issues one or two result transfers per queued frame.
module sccd_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  queue_empty,
    input  sccd_pkg::sccd_entry_t head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  write_valid,
    output logic [2:0]            target,
    output logic [7:0]            reg_addr,
    output logic [7:0]            write_data,
    output logic                  ack_valid,
    output logic [7:0]            ack_byte,
    output logic                  last
);

    logic       valid_reg;
    logic       wv_reg;
    logic [2:0] tgt_reg;
    logic [7:0] addr_reg;
    logic [7:0] data_reg;
    logic       av_reg;
    logic [7:0] ack_reg;
    logic       last_reg;
    logic       pend_reg;
    logic [7:0] pend_data_reg;
    logic       load;

    assign load = !valid_reg || !out_stall;
    assign pop  = load && !pend_reg && !queue_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else if (load)
        begin
            if (pend_reg)
            begin
                valid_reg <= 1'b1;
                pend_reg  <= 1'b0;
            end
            else
            begin
                valid_reg <= !queue_empty;
                pend_reg  <= !queue_empty && head.pair;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (pend_reg)
            begin
                addr_reg <= {addr_reg[7:1], 1'b1};
                data_reg <= pend_data_reg;
                last_reg <= 1'b1;
            end
            else
            begin
                wv_reg        <= head.write_valid;
                tgt_reg       <= head.target;
                addr_reg      <= head.reg_addr;
                data_reg      <= head.data_a;
                av_reg        <= head.ack_valid;
                ack_reg       <= head.ack_byte;
                last_reg      <= !head.pair;
                pend_data_reg <= head.data_b;
            end
        end
    end

    assign out_valid   = valid_reg;
    assign write_valid = wv_reg;
    assign target      = tgt_reg;
    assign reg_addr    = addr_reg;
    assign write_data  = data_reg;
    assign ack_valid   = av_reg;
    assign ack_byte    = ack_reg;
    assign last        = last_reg;

    a_pend_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> valid_reg)
        else $error("second write pending without a first on the output");

    a_notlast_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !last_reg) |-> pend_reg)
        else $error("non-final transfer without a pending second write");

    a_pair_second: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !last_reg && !out_stall) |=> (valid_reg && last_reg && reg_addr[0]))
        else $error("second write of a pair did not follow");

    a_ack_code: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && av_reg) |->
            (ack_reg == sccd_pkg::ACK_GOOD || ack_reg == sccd_pkg::ACK_BAD))
        else $error("bad acknowledge code");

    a_nopop_pend: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !pop)
        else $error("queue popped while a pair is half issued");

endmodule

@@ hdl/sound_chip_command_deframer.sv @@
// Top level: sound-chip command deframer, parser front end, frame queue and output back end.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  input   | in_valid, in_stall, rx_byte                    | byte in
//  output  | out_valid, out_stall, write_valid, target,     | result out
//          | reg_addr, write_data, ack_valid, ack_byte, last|
//
//  One byte per cycle is taken while the frame queue has room; the parser finishes a
//  frame in the cycle of its last byte and pushes it into the queue, from which the output
//  register loads it unless out_stall holds it. Only the double SCC write gives two results,
//  from the single output register, the second once the first is taken.
//  Reset clears parser phase, queue pointers and the output valid; no clearing pass.
//  in_stall rises only when the queue is full; the output register holds under out_stall.
module sound_chip_command_deframer
#(
    parameter int QUEUE_DEPTH = sccd_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       write_valid,
    output logic [2:0] target,
    output logic [7:0] reg_addr,
    output logic [7:0] write_data,
    output logic       ack_valid,
    output logic [7:0] ack_byte,
    output logic       last
);

    logic                  push;
    logic                  pop;
    logic                  queue_full;
    logic                  queue_empty;
    sccd_pkg::sccd_entry_t push_entry;
    sccd_pkg::sccd_entry_t head;

    sccd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .queue_full (queue_full),
        .rx_byte    (rx_byte),
        .in_stall   (in_stall),
        .push       (push),
        .push_entry (push_entry)
    );

    sccd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .empty      (queue_empty),
        .head       (head)
    );

    sccd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .write_valid (write_valid),
        .target      (target),
        .reg_addr    (reg_addr),
        .write_data  (write_data),
        .ack_valid   (ack_valid),
        .ack_byte    (ack_byte),
        .last        (last)
    );

endmodule

@@ tb/sound_chip_command_deframer_test.sv @@
// Self-checking test of the sound-chip command deframer with random framing and timing.

typedef enum logic [1:0] {WAIT_CMD, WAIT_OP1, WAIT_OP2, WAIT_LAST} parse_phase_t;

typedef struct packed {
    logic       write_valid;
    logic [2:0] target;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       ack_valid;
    logic [7:0] ack_byte;
    logic       last;
} chip_result_t;

class deframe_mirror;
    parse_phase_t phase;
    logic [7:0]   cmd;
    logic [7:0]   op1;
    logic [7:0]   op2;
    chip_result_t owed_results[$];
    int           errors;
    int           bytes_in;
    int           results_seen;
    int           writes_seen;
    int           acks_seen;

    function new();
        phase = WAIT_CMD;
        cmd = 8'h00;
        op1 = 8'h00;
        op2 = 8'h00;
        errors = 0;
        bytes_in = 0;
        results_seen = 0;
        writes_seen = 0;
        acks_seen = 0;
    endfunction

    function void add_result(logic wv, logic [2:0] tgt, logic [7:0] ra, logic [7:0] wd,
                             logic av, logic [7:0] ab, logic lst);
        chip_result_t r;
        r.write_valid = wv;
        r.target      = tgt;
        r.reg_addr    = ra;
        r.write_data  = wd;
        r.ack_valid   = av;
        r.ack_byte    = ab;
        r.last        = lst;
        owed_results.push_back(r);
    endfunction

    function int pending();
        return owed_results.size();
    endfunction

    // Called for every byte transfer accepted on the input side.
    function void note_byte(logic [7:0] b);
        logic [7:0] base;
        bytes_in++;
        case (phase)
            WAIT_CMD:
            begin
                if (b == sccd_pkg::CMD_SN_DATA || b == sccd_pkg::CMD_SN_VARIANT ||
                    b == sccd_pkg::CMD_FM || b == sccd_pkg::CMD_AY ||
                    b == sccd_pkg::CMD_GT || b == sccd_pkg::CMD_WT_PCM ||
                    b == sccd_pkg::CMD_SCC)
                begin
                    cmd = b;
                    phase = WAIT_OP1;
                end
            end
            WAIT_OP1:
            begin
                if (cmd == sccd_pkg::CMD_SN_DATA || cmd == sccd_pkg::CMD_SN_VARIANT)
                begin
                    phase = WAIT_CMD;
                    add_result(1'b1, (cmd == sccd_pkg::CMD_SN_DATA) ?
                                     sccd_pkg::TGT_SN_DATA : sccd_pkg::TGT_SN_VARIANT,
                               8'h00, b, 1'b0, 8'h00, 1'b1);
                end
                else
                begin
                    op1 = b;
                    phase = WAIT_OP2;
                end
            end
            WAIT_OP2:
            begin
                if (cmd == sccd_pkg::CMD_AY)
                begin
                    phase = WAIT_CMD;
                    add_result(1'b1, sccd_pkg::TGT_AY, op1, b, 1'b0, 8'h00, 1'b1);
                end
                else
                begin
                    op2 = b;
                    phase = WAIT_LAST;
                end
            end
            default:
            begin
                phase = WAIT_CMD;
                if (cmd == sccd_pkg::CMD_SCC)
                begin
                    base = {op1[6:0], 1'b0};
                    add_result(1'b1, sccd_pkg::TGT_SCC, base, op2, 1'b0, 8'h00, 1'b0);
                    add_result(1'b1, sccd_pkg::TGT_SCC, base | 8'h01, b, 1'b0, 8'h00, 1'b1);
                end
                else if ((cmd ^ op1 ^ op2) != b)
                begin
                    if (cmd != sccd_pkg::CMD_GT)
                        add_result(1'b0, 3'd0, 8'h00, 8'h00, 1'b1, sccd_pkg::ACK_BAD, 1'b1);
                end
                else if (cmd == sccd_pkg::CMD_GT)
                    add_result(1'b1, sccd_pkg::TGT_GT, op1, op2, 1'b0, 8'h00, 1'b1);
                else if (cmd == sccd_pkg::CMD_FM)
                    add_result(1'b1, sccd_pkg::TGT_FM, op1, op2, 1'b1,
                               sccd_pkg::ACK_GOOD, 1'b1);
                else
                    add_result(1'b1,
                               (op1 >= sccd_pkg::PCM_REG_LO && op1 <= sccd_pkg::PCM_REG_HI) ?
                               sccd_pkg::TGT_PCM : sccd_pkg::TGT_WT,
                               op1, op2, 1'b1, sccd_pkg::ACK_GOOD, 1'b1);
            end
        endcase
    endfunction

    task report(string what);
        if (errors < 40)
            $display("MISMATCH @%0t: %s", $time, what);
        errors++;
    endtask

    // Called for every result transfer accepted on the output side.
    task check_result(logic wv, logic [2:0] tgt, logic [7:0] ra, logic [7:0] wd,
                      logic av, logic [7:0] ab, logic lst);
        chip_result_t want;
        results_seen++;
        if (wv === 1'b1)
            writes_seen++;
        if (av === 1'b1)
            acks_seen++;
        if (owed_results.size() == 0)
        begin
            report("result transfer with nothing outstanding");
            return;
        end
        want = owed_results.pop_front();
        if (wv !== want.write_valid)
            report($sformatf("write_valid %b, want %b", wv, want.write_valid));
        if (tgt !== want.target)
            report($sformatf("target %0d, want %0d", tgt, want.target));
        if (ra !== want.reg_addr)
            report($sformatf("reg_addr %h, want %h", ra, want.reg_addr));
        if (wd !== want.write_data)
            report($sformatf("write_data %h, want %h", wd, want.write_data));
        if (av !== want.ack_valid)
            report($sformatf("ack_valid %b, want %b", av, want.ack_valid));
        if (ab !== want.ack_byte)
            report($sformatf("ack_byte %h, want %h", ab, want.ack_byte));
        if (lst !== want.last)
            report($sformatf("last %b, want %b", lst, want.last));
    endtask
endclass

module sound_chip_command_deframer_test;

    localparam int STALL_LIMIT = 2000;

    localparam logic [7:0] CMD_IGNORED_B3 = 8'hB3;
    localparam logic [7:0] CMD_IGNORED_B4 = 8'hB4;
    localparam logic [7:0] CMD_IGNORED_BD = 8'hBD;

    localparam logic [6:0][7:0] FRAME_CMDS = {sccd_pkg::CMD_SN_DATA, sccd_pkg::CMD_SN_VARIANT,
                                              sccd_pkg::CMD_FM, sccd_pkg::CMD_AY,
                                              sccd_pkg::CMD_GT, sccd_pkg::CMD_WT_PCM,
                                              sccd_pkg::CMD_SCC};
    localparam logic [3:0][7:0] PCM_EDGES = {sccd_pkg::PCM_REG_LO - 8'd1, sccd_pkg::PCM_REG_LO,
                                             sccd_pkg::PCM_REG_HI, sccd_pkg::PCM_REG_HI + 8'd1};

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall;
    logic       write_valid;
    logic [2:0] target;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       ack_valid;
    logic [7:0] ack_byte;
    logic       last;

    deframe_mirror mirror;
    int            idle_pct;
    int            stall_pct;
    int            quiet_cycles;

    sound_chip_command_deframer DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .write_valid (write_valid),
        .target      (target),
        .reg_addr    (reg_addr),
        .write_data  (write_data),
        .ack_valid   (ack_valid),
        .ack_byte    (ack_byte),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Result side: check accepted transfers, then pick the next stall.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
                mirror.check_result(write_valid, target, reg_addr, write_data,
                                    ack_valid, ack_byte, last);
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("** sound_chip_command_deframer: FAILED **");
                $finish;
            end
        end
    end

    task send_byte(input logic [7:0] b);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            rx_byte <= 8'($urandom_range(255));
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        mirror.note_byte(b);
    endtask

    task send_check_frame(input logic [7:0] c, input logic [7:0] r, input logic [7:0] d,
                          input bit good);
        send_byte(c);
        send_byte(r);
        send_byte(d);
        send_byte(good ? (c ^ r ^ d) : (c ^ r ^ d ^ 8'($urandom_range(1, 255))));
    endtask

    task run_phase(input int idle, input int stall, input int n);
        int         sent;
        logic [7:0] c;
        logic [7:0] r;
        logic [7:0] d;
        idle_pct = idle;
        stall_pct = stall;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(99) < 8)
                send_byte(8'($urandom_range(255)));
            else
            begin
                c = FRAME_CMDS[$urandom_range(6)];
                r = 8'($urandom_range(255));
                d = 8'($urandom_range(255));
                if (c == sccd_pkg::CMD_WT_PCM && $urandom_range(3) == 0)
                    r = PCM_EDGES[$urandom_range(3)];
                if (c == sccd_pkg::CMD_SN_DATA || c == sccd_pkg::CMD_SN_VARIANT)
                begin
                    send_byte(c);
                    send_byte(r);
                    sent += 2;
                end
                else if (c == sccd_pkg::CMD_AY)
                begin
                    send_byte(c);
                    send_byte(r);
                    send_byte(d);
                    sent += 3;
                end
                else if (c == sccd_pkg::CMD_SCC)
                begin
                    send_byte(c);
                    send_byte(r);
                    send_byte(d);
                    send_byte(8'($urandom_range(255)));
                    sent += 4;
                end
                else
                begin
                    send_check_frame(c, r, d, $urandom_range(99) < 70);
                    sent += 4;
                end
            end
        end
    endtask

    initial
    begin
        mirror = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = 8'h00;
        idle_pct = 0;
        stall_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames, operand equal to a command code, ignored bytes
        send_byte(CMD_IGNORED_B3);
        send_byte(sccd_pkg::CMD_SN_DATA);
        send_byte(8'h00);
        send_byte(sccd_pkg::CMD_SN_VARIANT);
        send_byte(8'hFF);
        send_byte(sccd_pkg::CMD_AY);
        send_byte(8'hFF);
        send_byte(sccd_pkg::CMD_SN_DATA);
        send_check_frame(sccd_pkg::CMD_GT, 8'h00, 8'hFF, 1'b1);
        send_check_frame(sccd_pkg::CMD_FM, 8'h3C, 8'hA5, 1'b0);
        send_check_frame(sccd_pkg::CMD_WT_PCM, sccd_pkg::PCM_REG_LO, 8'h5A, 1'b1);
        send_byte(sccd_pkg::CMD_SCC);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CMD_IGNORED_B4);
        send_byte(CMD_IGNORED_BD);

        run_phase(0, 0, 200);
        run_phase(58, 0, 200);
        run_phase(0, 58, 200);
        run_phase(7, 7, 200);
        in_valid <= 1'b0;

        while (mirror.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d bytes over four timing phases.", mirror.bytes_in);
        $display("Checked %0d results (%0d writes, %0d acks); mismatches: %0d",
                 mirror.results_seen, mirror.writes_seen, mirror.acks_seen, mirror.errors);
        if (mirror.errors == 0)
            $display("** sound_chip_command_deframer: PASSED **");
        else
            $display("** sound_chip_command_deframer: FAILED **");
        $finish;
    end

endmodule
